// File: design/ctb_pkg.sv
// Shared state codes, context codes, a configuration register index and byte constants of the token boundary step.
package ctb_pkg;

  localparam int unsigned STATE_W = 6;
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned CHAR_W  = 8;

  typedef logic [STATE_W-1:0] lex_state_t;
  typedef logic [MODE_W-1:0]  pp_mode_t;
  typedef logic [CHAR_W-1:0]  char_t;

  // lexer states, dense encoding
  localparam lex_state_t ST_DEFAULT  = 6'd0;
  localparam lex_state_t ST_IDENT    = 6'd1;
  localparam lex_state_t ST_POUND    = 6'd2;
  localparam lex_state_t ST_PP       = 6'd3;
  localparam lex_state_t ST_PPDEF    = 6'd4;
  localparam lex_state_t ST_PRE_R    = 6'd5;
  localparam lex_state_t ST_PRE_LU8  = 6'd6;
  localparam lex_state_t ST_PRE_U    = 6'd7;
  localparam lex_state_t ST_NUM      = 6'd8;
  localparam lex_state_t ST_NUM0     = 6'd9;
  localparam lex_state_t ST_FLOAT    = 6'd10;
  localparam lex_state_t ST_EXP0     = 6'd11;
  localparam lex_state_t ST_EXP1     = 6'd12;
  localparam lex_state_t ST_HEX      = 6'd13;
  localparam lex_state_t ST_DOT      = 6'd14;
  localparam lex_state_t ST_ELLIPSIS = 6'd15;
  localparam lex_state_t ST_LESS     = 6'd16;
  localparam lex_state_t ST_LESS2    = 6'd17;
  localparam lex_state_t ST_MORE     = 6'd18;
  localparam lex_state_t ST_MORE2    = 6'd19;
  localparam lex_state_t ST_CPRE     = 6'd20;
  localparam lex_state_t ST_LCOM     = 6'd21;
  localparam lex_state_t ST_LCOM_BS  = 6'd22;
  localparam lex_state_t ST_BCOM     = 6'd23;
  localparam lex_state_t ST_BCOM_END = 6'd24;
  localparam lex_state_t ST_MINUS    = 6'd25;
  localparam lex_state_t ST_ARROW    = 6'd26;
  localparam lex_state_t ST_AND      = 6'd27;
  localparam lex_state_t ST_OR       = 6'd28;
  localparam lex_state_t ST_PLUS     = 6'd29;
  localparam lex_state_t ST_COLON    = 6'd30;
  localparam lex_state_t ST_SINGLE   = 6'd31;
  localparam lex_state_t ST_ERRMSG   = 6'd32;
  localparam lex_state_t ST_CHAR     = 6'd33;
  localparam lex_state_t ST_STR      = 6'd34;
  localparam lex_state_t ST_RAW      = 6'd35;
  localparam lex_state_t ST_INCL     = 6'd36;
  localparam lex_state_t ST_SENTINEL = 6'd37;

  // preprocessor contexts
  localparam pp_mode_t PP_DEFAULT = 4'd0;
  localparam pp_mode_t PP_INCLUDE = 4'd1;
  localparam pp_mode_t PP_ERROR   = 4'd7;

  // configuration register index
  localparam int unsigned REG_QUOTES_AS_IDENT = 0;

  // source bytes
  localparam char_t CH_NUL    = 8'h00;
  localparam char_t CH_VT     = 8'h0B;
  localparam char_t CH_FF     = 8'h0C;
  localparam char_t CH_CR     = 8'h0D;
  localparam char_t CH_LF     = 8'h0A;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_BANG   = 8'h21;
  localparam char_t CH_DQUOTE = 8'h22;
  localparam char_t CH_POUND  = 8'h23;
  localparam char_t CH_DOLLAR = 8'h24;
  localparam char_t CH_PCT    = 8'h25;
  localparam char_t CH_AMP    = 8'h26;
  localparam char_t CH_SQUOTE = 8'h27;
  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_RPAREN = 8'h29;
  localparam char_t CH_STAR   = 8'h2A;
  localparam char_t CH_PLUS   = 8'h2B;
  localparam char_t CH_COMMA  = 8'h2C;
  localparam char_t CH_MINUS  = 8'h2D;
  localparam char_t CH_DOT    = 8'h2E;
  localparam char_t CH_SLASH  = 8'h2F;
  localparam char_t CH_0      = 8'h30;
  localparam char_t CH_1      = 8'h31;
  localparam char_t CH_8      = 8'h38;
  localparam char_t CH_9      = 8'h39;
  localparam char_t CH_COLON  = 8'h3A;
  localparam char_t CH_SEMI   = 8'h3B;
  localparam char_t CH_LT     = 8'h3C;
  localparam char_t CH_EQ     = 8'h3D;
  localparam char_t CH_GT     = 8'h3E;
  localparam char_t CH_QMARK  = 8'h3F;
  localparam char_t CH_AT     = 8'h40;
  localparam char_t CH_UC_A   = 8'h41;
  localparam char_t CH_UC_F   = 8'h46;
  localparam char_t CH_UC_L   = 8'h4C;
  localparam char_t CH_UC_R   = 8'h52;
  localparam char_t CH_UC_U   = 8'h55;
  localparam char_t CH_UC_Z   = 8'h5A;
  localparam char_t CH_LBRACK = 8'h5B;
  localparam char_t CH_BSLASH = 8'h5C;
  localparam char_t CH_RBRACK = 8'h5D;
  localparam char_t CH_CARET  = 8'h5E;
  localparam char_t CH_UNDER  = 8'h5F;
  localparam char_t CH_LC_A   = 8'h61;
  localparam char_t CH_LC_E   = 8'h65;
  localparam char_t CH_LC_F   = 8'h66;
  localparam char_t CH_LC_U   = 8'h75;
  localparam char_t CH_LC_X   = 8'h78;
  localparam char_t CH_LC_Z   = 8'h7A;
  localparam char_t CH_LBRACE = 8'h7B;
  localparam char_t CH_PIPE   = 8'h7C;
  localparam char_t CH_RBRACE = 8'h7D;
  localparam char_t CH_TILDE  = 8'h7E;

endpackage

// File: design/cpp_token_boundary_step.sv
// Top level: one transition of the C/C++ tokenizer automaton per input word.
//
// Each input word carries a lexer state, a preprocessor context and one source byte; the
// block returns the next lexer state with tlast set when the token ends at that byte.
// A word is held in the input register at acceptance and moves on to the output register
// once that register is empty or being read (the transition decode sits between the two
// registers), and a new word is taken every cycle as long as the output side keeps up; a
// stalled output backs up through both registers before in_tready drops. The block does
// not feed the next state back by itself: the user returns out_tdata's state with the
// following byte. The user must write the quotes_as_identifier register (configuration
// byte address 0) only while the block is idle; the block itself does not enforce this.
module cpp_token_boundary_step (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [5:0] current_state, [9:6] pp_mode, [17:10] char_byte, [23:18] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // out_tdata: [5:0] next_state, [7:6] zero; out_tlast: token_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic quotes_id_r;

  logic                s1_vld_r;
  ctb_pkg::lex_state_t s1_state_r;
  ctb_pkg::pp_mode_t   s1_mode_r;
  ctb_pkg::char_t      s1_char_r;

  logic                out_vld_r;
  ctb_pkg::lex_state_t out_state_r;
  logic                out_end_r;

  logic                s1_adv;
  ctb_pkg::lex_state_t state_nxt;
  logic                end_nxt;

  logic c_digit, c_alpha, c_high, c_quote_id, c_ident_any, c_ident_letters, c_ident_start;
  logic c_hex;
  logic reg_sel;

  // configuration
  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[2] == 1'(ctb_pkg::REG_QUOTES_AS_IDENT));
  assign cfg_prdata = reg_sel ? {31'd0, quotes_id_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quotes_id_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      quotes_id_r <= cfg_pwdata[0];
    end
  end

  // two-stage flow control
  assign s1_adv    = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) s1_vld_r <= in_tvalid;
      if (s1_adv)    out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_state_r <= in_tdata[5:0];
      s1_mode_r  <= in_tdata[9:6];
      s1_char_r  <= in_tdata[17:10];
    end
    if (s1_vld_r && s1_adv) begin
      out_state_r <= state_nxt;
      out_end_r   <= end_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_state_r};
  assign out_tlast  = out_end_r;

  // byte classes
  always_comb begin
    c_digit    = (s1_char_r >= ctb_pkg::CH_0) && (s1_char_r <= ctb_pkg::CH_9);
    c_alpha    = ((s1_char_r >= ctb_pkg::CH_LC_A) && (s1_char_r <= ctb_pkg::CH_LC_Z)) ||
                 ((s1_char_r >= ctb_pkg::CH_UC_A) && (s1_char_r <= ctb_pkg::CH_UC_Z));
    c_high     = s1_char_r[7];
    c_quote_id = quotes_id_r &&
                 ((s1_char_r == ctb_pkg::CH_SQUOTE) || (s1_char_r == ctb_pkg::CH_DQUOTE));
    c_ident_letters = c_alpha || c_high || c_quote_id;
    c_ident_start   = c_ident_letters || (s1_char_r == ctb_pkg::CH_UNDER) ||
                      (s1_char_r == ctb_pkg::CH_DOLLAR);
    c_ident_any     = c_ident_start || c_digit;
    c_hex      = c_digit || c_high ||
                 ((s1_char_r >= ctb_pkg::CH_LC_A) && (s1_char_r <= ctb_pkg::CH_LC_F)) ||
                 ((s1_char_r >= ctb_pkg::CH_UC_A) && (s1_char_r <= ctb_pkg::CH_UC_F));
  end

  // transition decode
  always_comb begin
    state_nxt = s1_state_r;
    end_nxt   = 1'b0;
    if (s1_char_r == ctb_pkg::CH_NUL) begin
      end_nxt = 1'b1;
    end else if (s1_mode_r == ctb_pkg::PP_ERROR) begin
      state_nxt = ctb_pkg::ST_ERRMSG;
      end_nxt   = (s1_char_r == ctb_pkg::CH_LF);
    end else begin
      case (s1_state_r)
        ctb_pkg::ST_DEFAULT: begin
          if (s1_char_r == ctb_pkg::CH_UC_R) begin
            state_nxt = ctb_pkg::ST_PRE_R;
          end else if (s1_char_r == ctb_pkg::CH_UC_U || s1_char_r == ctb_pkg::CH_UC_L) begin
            state_nxt = ctb_pkg::ST_PRE_LU8;
          end else if (s1_char_r == ctb_pkg::CH_LC_U) begin
            state_nxt = ctb_pkg::ST_PRE_U;
          end else if (c_ident_start) begin
            state_nxt = ctb_pkg::ST_IDENT;
          end else if (s1_char_r >= ctb_pkg::CH_1 && s1_char_r <= ctb_pkg::CH_9) begin
            state_nxt = ctb_pkg::ST_NUM;
          end else if (s1_char_r == ctb_pkg::CH_0) begin
            state_nxt = ctb_pkg::ST_NUM0;
          end else begin
            case (s1_char_r)
              ctb_pkg::CH_SQUOTE: begin
                state_nxt = ctb_pkg::ST_CHAR;
                end_nxt   = 1'b1;
              end
              ctb_pkg::CH_DQUOTE: begin
                state_nxt = ctb_pkg::ST_STR;
                end_nxt   = 1'b1;
              end
              ctb_pkg::CH_SLASH: state_nxt = ctb_pkg::ST_CPRE;
              ctb_pkg::CH_DOT:   state_nxt = ctb_pkg::ST_DOT;
              ctb_pkg::CH_LT: begin
                // include context turns '<' into a header name unless quotes count as identifiers
                if (s1_mode_r == ctb_pkg::PP_INCLUDE && !quotes_id_r) begin
                  state_nxt = ctb_pkg::ST_INCL;
                  end_nxt   = 1'b1;
                end else begin
                  state_nxt = ctb_pkg::ST_LESS;
                end
              end
              ctb_pkg::CH_GT:    state_nxt = ctb_pkg::ST_MORE;
              ctb_pkg::CH_MINUS: state_nxt = ctb_pkg::ST_MINUS;
              ctb_pkg::CH_AMP:   state_nxt = ctb_pkg::ST_AND;
              ctb_pkg::CH_PIPE:  state_nxt = ctb_pkg::ST_OR;
              ctb_pkg::CH_PLUS:  state_nxt = ctb_pkg::ST_PLUS;
              ctb_pkg::CH_COLON: state_nxt = ctb_pkg::ST_COLON;
              ctb_pkg::CH_STAR, ctb_pkg::CH_PCT, ctb_pkg::CH_CARET, ctb_pkg::CH_EQ,
              ctb_pkg::CH_BANG:  state_nxt = ctb_pkg::ST_SINGLE;
              ctb_pkg::CH_POUND:
                state_nxt = (s1_mode_r == ctb_pkg::PP_DEFAULT) ? ctb_pkg::ST_PP
                                                               : ctb_pkg::ST_POUND;
              ctb_pkg::CH_LBRACE, ctb_pkg::CH_RBRACE, ctb_pkg::CH_LBRACK,
              ctb_pkg::CH_RBRACK, ctb_pkg::CH_LPAREN, ctb_pkg::CH_RPAREN,
              ctb_pkg::CH_TILDE, ctb_pkg::CH_COMMA, ctb_pkg::CH_SEMI,
              ctb_pkg::CH_QMARK, ctb_pkg::CH_AT, ctb_pkg::CH_BSLASH:
                end_nxt = 1'b1;
              default: ;
            endcase
          end
        end
        ctb_pkg::ST_IDENT: end_nxt = !c_ident_any;
        ctb_pkg::ST_POUND: end_nxt = 1'b1;
        ctb_pkg::ST_PP: begin
          if (!(s1_char_r == ctb_pkg::CH_SPACE || s1_char_r == ctb_pkg::CH_CR ||
                s1_char_r == ctb_pkg::CH_VT || s1_char_r == ctb_pkg::CH_FF)) begin
            if (c_ident_letters) state_nxt = ctb_pkg::ST_PPDEF;
            else                 end_nxt   = 1'b1;
          end
        end
        ctb_pkg::ST_PPDEF: end_nxt = !c_ident_letters;
        ctb_pkg::ST_PRE_R: begin
          if (quotes_id_r) begin
            state_nxt = ctb_pkg::ST_SENTINEL;
            end_nxt   = 1'b1;
          end else if (s1_char_r == ctb_pkg::CH_DQUOTE) begin
            state_nxt = ctb_pkg::ST_RAW;
            end_nxt   = 1'b1;
          end else begin
            state_nxt = ctb_pkg::ST_IDENT;
            end_nxt   = !c_ident_any;
          end
        end
        ctb_pkg::ST_PRE_LU8, ctb_pkg::ST_PRE_U: begin
          if (quotes_id_r) begin
            state_nxt = ctb_pkg::ST_SENTINEL;
            end_nxt   = 1'b1;
          end else if (s1_char_r == ctb_pkg::CH_DQUOTE) begin
            state_nxt = ctb_pkg::ST_STR;
            end_nxt   = 1'b1;
          end else if (s1_char_r == ctb_pkg::CH_SQUOTE) begin
            state_nxt = ctb_pkg::ST_CHAR;
            end_nxt   = 1'b1;
          end else if (s1_char_r == ctb_pkg::CH_UC_R) begin
            state_nxt = ctb_pkg::ST_PRE_R;
          end else if (s1_char_r == ctb_pkg::CH_8 && s1_state_r == ctb_pkg::ST_PRE_U) begin
            state_nxt = ctb_pkg::ST_PRE_LU8;
          end else begin
            state_nxt = ctb_pkg::ST_IDENT;
            end_nxt   = !c_ident_any;
          end
        end
        ctb_pkg::ST_NUM: begin
          if (!c_digit) begin
            if (s1_char_r == ctb_pkg::CH_DOT) state_nxt = ctb_pkg::ST_FLOAT;
            else                              end_nxt   = 1'b1;
          end
        end
        ctb_pkg::ST_NUM0: begin
          if (c_digit)                           state_nxt = ctb_pkg::ST_NUM;
          else if (s1_char_r == ctb_pkg::CH_LC_X) state_nxt = ctb_pkg::ST_HEX;
          else if (s1_char_r == ctb_pkg::CH_DOT)  state_nxt = ctb_pkg::ST_FLOAT;
          else                                   end_nxt   = 1'b1;
        end
        ctb_pkg::ST_FLOAT: begin
          if (!c_digit) begin
            if (s1_char_r == ctb_pkg::CH_LC_E) state_nxt = ctb_pkg::ST_EXP0;
            else                               end_nxt   = 1'b1;
          end
        end
        ctb_pkg::ST_EXP0: begin
          if (c_digit || s1_char_r == ctb_pkg::CH_MINUS) state_nxt = ctb_pkg::ST_EXP1;
          else                                           end_nxt   = 1'b1;
        end
        ctb_pkg::ST_EXP1: end_nxt = !c_digit;
        ctb_pkg::ST_HEX:  end_nxt = !c_hex;
        ctb_pkg::ST_DOT: begin
          if (c_digit)                          state_nxt = ctb_pkg::ST_FLOAT;
          else if (s1_char_r == ctb_pkg::CH_DOT) state_nxt = ctb_pkg::ST_ELLIPSIS;
          else                                  end_nxt   = 1'b1;
        end
        ctb_pkg::ST_LESS: begin
          if (s1_char_r == ctb_pkg::CH_LT) state_nxt = ctb_pkg::ST_LESS2;
          else                             end_nxt   = 1'b1;
        end
        ctb_pkg::ST_MORE: begin
          if (s1_char_r == ctb_pkg::CH_GT) state_nxt = ctb_pkg::ST_MORE2;
          else                             end_nxt   = 1'b1;
        end
        ctb_pkg::ST_CPRE: begin
          if (s1_char_r == ctb_pkg::CH_SLASH)     state_nxt = ctb_pkg::ST_LCOM;
          else if (s1_char_r == ctb_pkg::CH_STAR) state_nxt = ctb_pkg::ST_BCOM;
          else                                    end_nxt   = 1'b1;
        end
        ctb_pkg::ST_LCOM: begin
          if (s1_char_r == ctb_pkg::CH_BSLASH)  state_nxt = ctb_pkg::ST_LCOM_BS;
          else if (s1_char_r == ctb_pkg::CH_LF) end_nxt   = 1'b1;
        end
        ctb_pkg::ST_LCOM_BS: begin
          // a CR/FF/VT after the backslash keeps the continuation pending
          if (!(s1_char_r == ctb_pkg::CH_CR || s1_char_r == ctb_pkg::CH_FF ||
                s1_char_r == ctb_pkg::CH_VT))
            state_nxt = ctb_pkg::ST_LCOM;
        end
        ctb_pkg::ST_BCOM: begin
          if (s1_char_r == ctb_pkg::CH_STAR) state_nxt = ctb_pkg::ST_BCOM_END;
        end
        ctb_pkg::ST_BCOM_END: begin
          if (s1_char_r == ctb_pkg::CH_SLASH)      end_nxt   = 1'b1;
          else if (s1_char_r != ctb_pkg::CH_STAR)  state_nxt = ctb_pkg::ST_BCOM;
        end
        ctb_pkg::ST_MINUS: begin
          if (s1_char_r == ctb_pkg::CH_GT) state_nxt = ctb_pkg::ST_ARROW;
          else                             end_nxt   = 1'b1;
        end
        ctb_pkg::ST_ELLIPSIS, ctb_pkg::ST_LESS2, ctb_pkg::ST_MORE2, ctb_pkg::ST_ARROW,
        ctb_pkg::ST_AND, ctb_pkg::ST_OR, ctb_pkg::ST_PLUS, ctb_pkg::ST_COLON,
        ctb_pkg::ST_SINGLE:
          end_nxt = 1'b1;
        // terminal and unused codes hold
        default: ;
      endcase
    end
  end

endmodule

// File: verif/cpp_token_boundary_step_tb.sv
// Testbench for cpp_token_boundary_step: stream traffic with a local transition predictor.
module cpp_token_boundary_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam ctb_pkg::char_t CH_TAB     = 8'h09;
  localparam ctb_pkg::char_t CH_HIGH    = 8'h80;
  localparam int             IDLE_LIMIT = 2000;
  localparam int             HOLD_LEN   = 80;

  typedef struct packed {
    ctb_pkg::lex_state_t state;
    ctb_pkg::pp_mode_t   mode;
    ctb_pkg::char_t      ch;
  } lex_in_t;

  typedef struct {
    ctb_pkg::lex_state_t next;
    logic                tend;
  } lex_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  cpp_token_boundary_step u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  lex_in_t  src_word_q[$];
  lex_out_t step_result_q[$];
  lex_in_t  held_word;
  logic     quote_shadow = 1'b0;

  int items_queued  = 0;
  int items_taken   = 0;
  int results_seen  = 0;
  int token_ends    = 0;
  int fault_count   = 0;
  int settings_used = 1;
  int in_stall_cyc  = 0;
  int idle_cycles   = 0;
  int gap_left      = 0;
  int burst_left    = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int rx_tick       = 0;

  ctb_pkg::char_t letter_set [14] = '{
    ctb_pkg::CH_UC_R, ctb_pkg::CH_UC_U, ctb_pkg::CH_UC_L, ctb_pkg::CH_LC_U,
    ctb_pkg::CH_LC_X, ctb_pkg::CH_LC_E, ctb_pkg::CH_LC_A, ctb_pkg::CH_LC_F,
    ctb_pkg::CH_UC_A, ctb_pkg::CH_UC_F, ctb_pkg::CH_UC_Z, ctb_pkg::CH_LC_Z,
    ctb_pkg::CH_UNDER, ctb_pkg::CH_DOLLAR};
  ctb_pkg::char_t punct_set [28] = '{
    ctb_pkg::CH_SLASH, ctb_pkg::CH_STAR, ctb_pkg::CH_DOT, ctb_pkg::CH_LT, ctb_pkg::CH_GT,
    ctb_pkg::CH_MINUS, ctb_pkg::CH_AMP, ctb_pkg::CH_PIPE, ctb_pkg::CH_PLUS,
    ctb_pkg::CH_COLON, ctb_pkg::CH_PCT, ctb_pkg::CH_CARET, ctb_pkg::CH_EQ,
    ctb_pkg::CH_BANG, ctb_pkg::CH_POUND, ctb_pkg::CH_LBRACE, ctb_pkg::CH_RBRACE,
    ctb_pkg::CH_LBRACK, ctb_pkg::CH_RBRACK, ctb_pkg::CH_LPAREN, ctb_pkg::CH_RPAREN,
    ctb_pkg::CH_TILDE, ctb_pkg::CH_COMMA, ctb_pkg::CH_SEMI, ctb_pkg::CH_QMARK,
    ctb_pkg::CH_AT, ctb_pkg::CH_BSLASH, ctb_pkg::CH_SLASH};
  ctb_pkg::char_t space_set [6] = '{ctb_pkg::CH_SPACE, ctb_pkg::CH_LF, ctb_pkg::CH_CR,
                                    ctb_pkg::CH_VT, ctb_pkg::CH_FF, CH_TAB};

  initial begin
    forever #5 clk = ~clk;
  end

  // character classes
  function automatic logic is_dig(ctb_pkg::char_t c);
    return c >= ctb_pkg::CH_0 && c <= ctb_pkg::CH_9;
  endfunction

  function automatic logic is_alp(ctb_pkg::char_t c);
    return (c >= ctb_pkg::CH_LC_A && c <= ctb_pkg::CH_LC_Z) ||
           (c >= ctb_pkg::CH_UC_A && c <= ctb_pkg::CH_UC_Z);
  endfunction

  function automatic logic quote_ident(ctb_pkg::char_t c, logic qid);
    return qid && (c == ctb_pkg::CH_SQUOTE || c == ctb_pkg::CH_DQUOTE);
  endfunction

  function automatic logic id_letter(ctb_pkg::char_t c, logic qid);
    return is_alp(c) || c >= CH_HIGH || quote_ident(c, qid);
  endfunction

  function automatic logic id_head(ctb_pkg::char_t c, logic qid);
    return id_letter(c, qid) || c == ctb_pkg::CH_UNDER || c == ctb_pkg::CH_DOLLAR;
  endfunction

  function automatic logic id_body(ctb_pkg::char_t c, logic qid);
    return id_head(c, qid) || is_dig(c);
  endfunction

  function automatic lex_out_t lex_transition(lex_in_t w, logic qid);
    lex_out_t       r;
    ctb_pkg::char_t c;
    c = w.ch;
    r.next = w.state;
    r.tend = 1'b0;
    if (c == ctb_pkg::CH_NUL) begin
      r.tend = 1'b1;
    end else if (w.mode == ctb_pkg::PP_ERROR) begin
      r.next = ctb_pkg::ST_ERRMSG;
      r.tend = (c == ctb_pkg::CH_LF);
    end else begin
      case (w.state)
        ctb_pkg::ST_DEFAULT: begin
          if (c == ctb_pkg::CH_UC_R) r.next = ctb_pkg::ST_PRE_R;
          else if (c == ctb_pkg::CH_UC_U || c == ctb_pkg::CH_UC_L) r.next = ctb_pkg::ST_PRE_LU8;
          else if (c == ctb_pkg::CH_LC_U) r.next = ctb_pkg::ST_PRE_U;
          else if (id_head(c, qid)) r.next = ctb_pkg::ST_IDENT;
          else if (c >= ctb_pkg::CH_1 && c <= ctb_pkg::CH_9) r.next = ctb_pkg::ST_NUM;
          else if (c == ctb_pkg::CH_0) r.next = ctb_pkg::ST_NUM0;
          else begin
            case (c)
              ctb_pkg::CH_SQUOTE: begin
                r.next = ctb_pkg::ST_CHAR;
                r.tend = 1'b1;
              end
              ctb_pkg::CH_DQUOTE: begin
                r.next = ctb_pkg::ST_STR;
                r.tend = 1'b1;
              end
              ctb_pkg::CH_SLASH: r.next = ctb_pkg::ST_CPRE;
              ctb_pkg::CH_DOT:   r.next = ctb_pkg::ST_DOT;
              ctb_pkg::CH_LT: begin
                if (w.mode == ctb_pkg::PP_INCLUDE && !qid) begin
                  r.next = ctb_pkg::ST_INCL;
                  r.tend = 1'b1;
                end else begin
                  r.next = ctb_pkg::ST_LESS;
                end
              end
              ctb_pkg::CH_GT:    r.next = ctb_pkg::ST_MORE;
              ctb_pkg::CH_MINUS: r.next = ctb_pkg::ST_MINUS;
              ctb_pkg::CH_AMP:   r.next = ctb_pkg::ST_AND;
              ctb_pkg::CH_PIPE:  r.next = ctb_pkg::ST_OR;
              ctb_pkg::CH_PLUS:  r.next = ctb_pkg::ST_PLUS;
              ctb_pkg::CH_COLON: r.next = ctb_pkg::ST_COLON;
              ctb_pkg::CH_STAR, ctb_pkg::CH_PCT, ctb_pkg::CH_CARET, ctb_pkg::CH_EQ,
              ctb_pkg::CH_BANG: r.next = ctb_pkg::ST_SINGLE;
              ctb_pkg::CH_POUND:
                r.next = (w.mode == ctb_pkg::PP_DEFAULT) ? ctb_pkg::ST_PP : ctb_pkg::ST_POUND;
              ctb_pkg::CH_LBRACE, ctb_pkg::CH_RBRACE, ctb_pkg::CH_LBRACK, ctb_pkg::CH_RBRACK,
              ctb_pkg::CH_LPAREN, ctb_pkg::CH_RPAREN, ctb_pkg::CH_TILDE, ctb_pkg::CH_COMMA,
              ctb_pkg::CH_SEMI, ctb_pkg::CH_QMARK, ctb_pkg::CH_AT, ctb_pkg::CH_BSLASH:
                r.tend = 1'b1;
              default: ;
            endcase
          end
        end
        ctb_pkg::ST_IDENT: r.tend = !id_body(c, qid);
        ctb_pkg::ST_POUND: r.tend = 1'b1;
        ctb_pkg::ST_PP: begin
          if (!(c == ctb_pkg::CH_SPACE || c == ctb_pkg::CH_CR || c == ctb_pkg::CH_VT ||
                c == ctb_pkg::CH_FF)) begin
            if (id_letter(c, qid)) r.next = ctb_pkg::ST_PPDEF;
            else r.tend = 1'b1;
          end
        end
        ctb_pkg::ST_PPDEF: r.tend = !id_letter(c, qid);
        ctb_pkg::ST_PRE_R: begin
          if (qid) begin
            r.next = ctb_pkg::ST_SENTINEL;
            r.tend = 1'b1;
          end else if (c == ctb_pkg::CH_DQUOTE) begin
            r.next = ctb_pkg::ST_RAW;
            r.tend = 1'b1;
          end else begin
            r.next = ctb_pkg::ST_IDENT;
            r.tend = !id_body(c, qid);
          end
        end
        ctb_pkg::ST_PRE_LU8, ctb_pkg::ST_PRE_U: begin
          if (qid) begin
            r.next = ctb_pkg::ST_SENTINEL;
            r.tend = 1'b1;
          end else if (c == ctb_pkg::CH_DQUOTE) begin
            r.next = ctb_pkg::ST_STR;
            r.tend = 1'b1;
          end else if (c == ctb_pkg::CH_SQUOTE) begin
            r.next = ctb_pkg::ST_CHAR;
            r.tend = 1'b1;
          end else if (c == ctb_pkg::CH_UC_R) begin
            r.next = ctb_pkg::ST_PRE_R;
          end else if (c == ctb_pkg::CH_8 && w.state == ctb_pkg::ST_PRE_U) begin
            r.next = ctb_pkg::ST_PRE_LU8;
          end else begin
            r.next = ctb_pkg::ST_IDENT;
            r.tend = !id_body(c, qid);
          end
        end
        ctb_pkg::ST_NUM: begin
          if (!is_dig(c)) begin
            if (c == ctb_pkg::CH_DOT) r.next = ctb_pkg::ST_FLOAT;
            else r.tend = 1'b1;
          end
        end
        ctb_pkg::ST_NUM0: begin
          if (is_dig(c)) r.next = ctb_pkg::ST_NUM;
          else if (c == ctb_pkg::CH_LC_X) r.next = ctb_pkg::ST_HEX;
          else if (c == ctb_pkg::CH_DOT) r.next = ctb_pkg::ST_FLOAT;
          else r.tend = 1'b1;
        end
        ctb_pkg::ST_FLOAT: begin
          if (!is_dig(c)) begin
            if (c == ctb_pkg::CH_LC_E) r.next = ctb_pkg::ST_EXP0;
            else r.tend = 1'b1;
          end
        end
        ctb_pkg::ST_EXP0: begin
          if (is_dig(c) || c == ctb_pkg::CH_MINUS) r.next = ctb_pkg::ST_EXP1;
          else r.tend = 1'b1;
        end
        ctb_pkg::ST_EXP1: r.tend = !is_dig(c);
        ctb_pkg::ST_HEX:
          r.tend = !(is_dig(c) || (c >= ctb_pkg::CH_LC_A && c <= ctb_pkg::CH_LC_F) ||
                     (c >= ctb_pkg::CH_UC_A && c <= ctb_pkg::CH_UC_F) || c >= CH_HIGH);
        ctb_pkg::ST_DOT: begin
          if (is_dig(c)) r.next = ctb_pkg::ST_FLOAT;
          else if (c == ctb_pkg::CH_DOT) r.next = ctb_pkg::ST_ELLIPSIS;
          else r.tend = 1'b1;
        end
        ctb_pkg::ST_LESS: begin
          if (c == ctb_pkg::CH_LT) r.next = ctb_pkg::ST_LESS2;
          else r.tend = 1'b1;
        end
        ctb_pkg::ST_MORE: begin
          if (c == ctb_pkg::CH_GT) r.next = ctb_pkg::ST_MORE2;
          else r.tend = 1'b1;
        end
        ctb_pkg::ST_CPRE: begin
          if (c == ctb_pkg::CH_SLASH) r.next = ctb_pkg::ST_LCOM;
          else if (c == ctb_pkg::CH_STAR) r.next = ctb_pkg::ST_BCOM;
          else r.tend = 1'b1;
        end
        ctb_pkg::ST_LCOM: begin
          if (c == ctb_pkg::CH_BSLASH) r.next = ctb_pkg::ST_LCOM_BS;
          else if (c == ctb_pkg::CH_LF) r.tend = 1'b1;
        end
        ctb_pkg::ST_LCOM_BS: begin
          if (!(c == ctb_pkg::CH_CR || c == ctb_pkg::CH_FF || c == ctb_pkg::CH_VT))
            r.next = ctb_pkg::ST_LCOM;
        end
        ctb_pkg::ST_BCOM: begin
          if (c == ctb_pkg::CH_STAR) r.next = ctb_pkg::ST_BCOM_END;
        end
        ctb_pkg::ST_BCOM_END: begin
          if (c == ctb_pkg::CH_SLASH) r.tend = 1'b1;
          else if (c != ctb_pkg::CH_STAR) r.next = ctb_pkg::ST_BCOM;
        end
        ctb_pkg::ST_MINUS: begin
          if (c == ctb_pkg::CH_GT) r.next = ctb_pkg::ST_ARROW;
          else r.tend = 1'b1;
        end
        ctb_pkg::ST_ELLIPSIS, ctb_pkg::ST_LESS2, ctb_pkg::ST_MORE2, ctb_pkg::ST_ARROW,
        ctb_pkg::ST_AND, ctb_pkg::ST_OR, ctb_pkg::ST_PLUS, ctb_pkg::ST_COLON,
        ctb_pkg::ST_SINGLE: r.tend = 1'b1;
        default: ;  // terminal and unused codes hold
      endcase
    end
    return r;
  endfunction

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void push_word(ctb_pkg::lex_state_t st, ctb_pkg::pp_mode_t md,
                                    ctb_pkg::char_t ch);
    lex_in_t w;
    w.state = st;
    w.mode  = md;
    w.ch    = ch;
    src_word_q.push_back(w);
    items_queued++;
  endfunction

  // Mostly lexer-like runs that feed the predicted state back, plus raw noise words.
  task automatic queue_random(int n);
    lex_in_t             w;
    lex_out_t            r;
    ctb_pkg::lex_state_t st;
    ctb_pkg::pp_mode_t   md;
    int                  run_left;
    int                  sel;
    st = ctb_pkg::ST_DEFAULT;
    md = ctb_pkg::PP_DEFAULT;
    run_left = 0;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(4, 40);
        st = ctb_pkg::ST_DEFAULT;
        sel = $urandom_range(0, 99);
        if (sel < 55) md = ctb_pkg::PP_DEFAULT;
        else if (sel < 70) md = ctb_pkg::PP_INCLUDE;
        else if (sel < 78) md = ctb_pkg::PP_ERROR;
        else if (sel < 92) md = ($urandom_range(0, 5) == 0) ? 4'd8 : 4'($urandom_range(2, 6));
        else md = 4'($urandom_range(9, 15));
      end
      run_left--;
      if ($urandom_range(0, 4) == 0) begin
        w.state = 6'($urandom_range(0, 63));
        w.mode  = 4'($urandom_range(0, 15));
        w.ch    = 8'($urandom_range(0, 255));
      end else begin
        w.state = st;
        w.mode  = md;
        sel = $urandom_range(0, 99);
        if (sel < 22) w.ch = letter_set[$urandom_range(0, 13)];
        else if (sel < 30)
          w.ch = $urandom_range(0, 1) ? 8'($urandom_range(ctb_pkg::CH_LC_A, ctb_pkg::CH_LC_Z))
                                      : 8'($urandom_range(ctb_pkg::CH_UC_A, ctb_pkg::CH_UC_Z));
        else if (sel < 44) w.ch = 8'($urandom_range(ctb_pkg::CH_0, ctb_pkg::CH_9));
        else if (sel < 68) w.ch = punct_set[$urandom_range(0, 27)];
        else if (sel < 78) w.ch = space_set[$urandom_range(0, 5)];
        else if (sel < 86) w.ch = 8'($urandom_range(128, 255));
        else if (sel < 92) w.ch = $urandom_range(0, 1) ? ctb_pkg::CH_SQUOTE : ctb_pkg::CH_DQUOTE;
        else if (sel < 98) w.ch = 8'($urandom_range(1, 255));
        else w.ch = ctb_pkg::CH_NUL;
        r = lex_transition(w, quote_shadow);
        // a finished token, or a state that only a zero byte leaves, restarts the lexer
        st = (r.tend || r.next >= ctb_pkg::ST_CHAR) ? ctb_pkg::ST_DEFAULT : r.next;
      end
      src_word_q.push_back(w);
      items_queued++;
    end
  endtask

  task automatic drain();
    do @(negedge clk); while (items_taken != items_queued || step_result_q.size() != 0);
  endtask

  task automatic set_quote_mode(logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(ctb_pkg::REG_QUOTES_AS_IDENT * 4);
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    quote_shadow = val[0];
    settings_used++;
    // read back
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_pready);
    if (cfg_prdata !== {31'd0, val[0]})
      note_fault($sformatf("register readback: expected %h, got %h", {31'd0, val[0]},
                           cfg_prdata));
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin : drive_in
    lex_in_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        step_result_q.push_back(lex_transition(held_word, quote_shadow));
        items_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0 || src_word_q.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          w = src_word_q.pop_front();
          held_word <= w;
          in_tdata  <= {6'd0, w.ch, w.mode, w.state};
          in_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // receiver: rotating stall styles, plus one long hold-off that backs up the block
  always @(posedge clk) begin : drive_out
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_tick++;
      if (!hold_done && items_taken >= 200) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_tick[7:6])
          2'd0: out_tready <= 1'b1;
          2'd1: out_tready <= 1'($urandom_range(0, 1));
          2'd2: out_tready <= (rx_tick[1:0] == 2'd0);
          default: out_tready <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_out
    lex_out_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (step_result_q.size() == 0) begin
        note_fault($sformatf("result word with nothing pending: state %0d end %b",
                             out_tdata[5:0], out_tlast));
      end else begin
        e = step_result_q.pop_front();
        results_seen++;
        if (out_tlast) token_ends++;
        if (out_tdata[5:0] !== e.next || out_tlast !== e.tend || out_tdata[7:6] !== 2'b00)
          note_fault($sformatf("word %0d: expected state %0d end %b, got tdata %h end %b",
                               results_seen, e.next, e.tend, out_tdata, out_tlast));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if (in_tvalid && !in_tready) in_stall_cyc++;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
          $display("cpp_token_boundary_step regression: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    // directed words, quotes off
    push_word(ctb_pkg::ST_DEFAULT, ctb_pkg::PP_DEFAULT, ctb_pkg::CH_NUL);
    push_word(6'd63, 4'd15, 8'hFF);
    push_word(ctb_pkg::ST_SENTINEL, ctb_pkg::PP_DEFAULT, ctb_pkg::CH_LC_A);
    push_word(ctb_pkg::ST_CHAR, ctb_pkg::PP_INCLUDE, ctb_pkg::CH_NUL);
    push_word(ctb_pkg::ST_PRE_R, ctb_pkg::PP_ERROR, ctb_pkg::CH_LC_X);
    push_word(ctb_pkg::ST_ERRMSG, ctb_pkg::PP_ERROR, ctb_pkg::CH_LF);
    push_word(ctb_pkg::ST_DEFAULT, ctb_pkg::PP_INCLUDE, ctb_pkg::CH_LT);
    push_word(ctb_pkg::ST_DEFAULT, ctb_pkg::PP_DEFAULT, ctb_pkg::CH_LT);
    push_word(ctb_pkg::ST_DEFAULT, ctb_pkg::PP_DEFAULT, ctb_pkg::CH_POUND);
    push_word(ctb_pkg::ST_DEFAULT, 4'd2, ctb_pkg::CH_POUND);
    push_word(ctb_pkg::ST_DEFAULT, 4'd9, ctb_pkg::CH_POUND);
    push_word(ctb_pkg::ST_DEFAULT, ctb_pkg::PP_DEFAULT, ctb_pkg::CH_SPACE);
    push_word(ctb_pkg::ST_PRE_R, ctb_pkg::PP_DEFAULT, ctb_pkg::CH_DQUOTE);
    push_word(ctb_pkg::ST_PRE_U, ctb_pkg::PP_DEFAULT, ctb_pkg::CH_8);
    push_word(ctb_pkg::ST_PRE_LU8, ctb_pkg::PP_DEFAULT, ctb_pkg::CH_SQUOTE);
    push_word(ctb_pkg::ST_DEFAULT, ctb_pkg::PP_DEFAULT, ctb_pkg::CH_SQUOTE);
    push_word(ctb_pkg::ST_DEFAULT, ctb_pkg::PP_DEFAULT, 8'hFF);
    push_word(ctb_pkg::ST_BCOM_END, ctb_pkg::PP_DEFAULT, ctb_pkg::CH_SLASH);
    push_word(ctb_pkg::ST_LCOM_BS, ctb_pkg::PP_DEFAULT, ctb_pkg::CH_CR);
    push_word(ctb_pkg::ST_NUM0, ctb_pkg::PP_DEFAULT, ctb_pkg::CH_LC_X);
    push_word(ctb_pkg::ST_HEX, ctb_pkg::PP_DEFAULT, 8'h80);
    push_word(ctb_pkg::ST_EXP0, ctb_pkg::PP_DEFAULT, ctb_pkg::CH_MINUS);
    push_word(ctb_pkg::ST_PP, ctb_pkg::PP_DEFAULT, ctb_pkg::CH_SPACE);
    push_word(6'd45, 4'd3, ctb_pkg::CH_LC_A);
    queue_random(340);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    drain();

    set_quote_mode(32'h0000_0001);
    push_word(ctb_pkg::ST_PRE_R, ctb_pkg::PP_DEFAULT, ctb_pkg::CH_LC_A);
    push_word(ctb_pkg::ST_DEFAULT, ctb_pkg::PP_INCLUDE, ctb_pkg::CH_LT);
    push_word(ctb_pkg::ST_DEFAULT, ctb_pkg::PP_DEFAULT, ctb_pkg::CH_SQUOTE);
    push_word(ctb_pkg::ST_IDENT, ctb_pkg::PP_DEFAULT, ctb_pkg::CH_DQUOTE);
    push_word(ctb_pkg::ST_PRE_U, ctb_pkg::PP_DEFAULT, ctb_pkg::CH_NUL);
    queue_random(300);
    drain();

    // upper data bits set, register bit clear
    set_quote_mode(32'hFFFF_FFFE);
    queue_random(150);
    drain();

    set_quote_mode(32'hFFFF_FFFF);
    queue_random(90);
    drain();

    repeat (4) @(posedge clk);
    $display("checked %0d bytes (%0d token ends) across %0d quote settings",
             results_seen, token_ends, settings_used);
    $display("input backpressure seen for %0d cycles, including a %0d-cycle output hold",
             in_stall_cyc, HOLD_LEN);
    if (fault_count == 0 && step_result_q.size() == 0) begin
      $display("cpp_token_boundary_step regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", fault_count, step_result_q.size());
      $display("cpp_token_boundary_step regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
design/ctb_pkg.sv
design/cpp_token_boundary_step.sv
verif/cpp_token_boundary_step_tb.sv
